@@ hdl/ffha_pkg.sv @@
// Package: constants, types and state codes for the first-fit heap allocator.
package ffha_pkg;
    localparam int HEAP_BYTES   = 65536;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_W  = 17;
    localparam int ENT_W = SZ_W + 1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_GROW,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_SPLIT_END,
        S_CO_RD,
        S_CO_CHK,
        S_CO_SH_RD,
        S_CO_SH_WR,
        S_DONE
    } t_state;
endpackage

@@ hdl/ffha_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/first_fit_heap_allocator_core.sv @@
// Top level: first-fit heap allocator with split and coalesce over a block table.
//
// The block table (size and free mark) sits in one RAM with a registered read.
// A request walks the table one entry at a time, reading it in S_SCAN_RD and
// checking it in S_SCAN_CHK; an allocate that finds no fit grows the heap in
// S_GROW. A split then shifts the tail up one entry at a time, and a free runs a
// coalesce pass from the freed entry, or from the free entry before it, to the
// end of the table, shifting later entries down one place for each merge.
// s_axis_tready is low from acceptance until the result moves into the output
// register; if the previous result is still waiting there, the finished item
// holds in its last step until that result is taken. A new item can be
// accepted while a result waits.
module first_fit_heap_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // req_size[15:0], address[31:16]
    input  logic        s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status[1:0], address_out[17:2], zero pad
);
    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int SW = ffha_pkg::SZ_W;
    localparam int EW = ffha_pkg::ENT_W;

    ffha_pkg::t_state r_state, n_state;
    logic [16:0] r_limit;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_brk, n_brk;
    logic        r_mode;
    logic [SW-1:0] r_need;
    logic [15:0] r_addr;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_k, n_k;
    logic [SW-1:0] r_start, n_start;
    logic [SW-1:0] r_fsz, n_fsz;      // size of entry i (found / coalesce left)
    logic        r_ffree, n_ffree;
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_aout, n_aout;
    logic [1:0]  r_ostat, n_ostat;
    logic [15:0] r_oaddr, n_oaddr;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [SW-1:0] rsz;
    logic          rfree;
    logic [SW-1:0] sum;               // shared adder
    logic [SW-1:0] add_a, add_b;
    logic [SW-1:0] eff_lim;
    logic [17:0]   need_w;

    ffha_ram #(.WIDTH(EW), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rsz   = rdata[SW-1:0];
    assign rfree = rdata[SW];
    assign sum   = add_a + add_b;
    assign eff_lim = (r_limit > SW'(ffha_pkg::HEAP_BYTES)) ? SW'(ffha_pkg::HEAP_BYTES)
                                                          : r_limit;
    assign need_w = (18'(s_axis_tdata[15:0]) + 18'(ffha_pkg::HEADER_BYTES)
                     + 18'(ffha_pkg::ALIGN_BYTES - 1))
                    & ~18'(ffha_pkg::ALIGN_BYTES - 1);

    assign o_cfg_ready   = (r_state == ffha_pkg::S_IDLE) && !r_ovalid;
    assign s_axis_tready = (r_state == ffha_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_oaddr, r_ostat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffha_pkg::S_IDLE;
            r_limit  <= 17'd65536;
            r_cnt    <= '0;
            r_brk    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_brk    <= n_brk;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode <= s_axis_tuser;
            r_need <= need_w[SW-1:0];
            r_addr <= s_axis_tdata[31:16];
        end
        r_i     <= n_i;
        r_k     <= n_k;
        r_start <= n_start;
        r_fsz   <= n_fsz;
        r_ffree <= n_ffree;
        r_status <= n_status;
        r_aout  <= n_aout;
        r_ostat <= n_ostat;
        r_oaddr <= n_oaddr;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tuser && s_axis_tdata[31:16] == 16'd0) begin
                        n_state = ffha_pkg::S_DONE;
                    end else begin
                        n_state = ffha_pkg::S_SCAN_RD;
                    end
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                if (r_i >= r_cnt) begin
                    n_state = r_mode ? ffha_pkg::S_DONE : ffha_pkg::S_GROW;
                end else begin
                    n_state = ffha_pkg::S_SCAN_CHK;
                end
            end
            ffha_pkg::S_SCAN_CHK: begin
                if (!r_mode) begin
                    if (rfree && rsz >= r_need) begin
                        n_state = (rsz > r_need && r_cnt < CW'(ffha_pkg::MAX_BLOCKS))
                                  ? ffha_pkg::S_SPLIT_RD : ffha_pkg::S_DONE;
                    end else begin
                        n_state = ffha_pkg::S_SCAN_RD;
                    end
                end else if (r_start + SW'(ffha_pkg::HEADER_BYTES) == {1'b0, r_addr}) begin
                    n_state = rfree ? ffha_pkg::S_DONE : ffha_pkg::S_CO_RD;
                end else begin
                    n_state = ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_GROW: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_SPLIT_RD: begin
                n_state = (r_k > r_i + CW'(1)) ? ffha_pkg::S_SPLIT_WR
                                               : ffha_pkg::S_SPLIT_END;
            end
            ffha_pkg::S_SPLIT_WR: n_state = ffha_pkg::S_SPLIT_RD;
            ffha_pkg::S_SPLIT_END: n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_CO_RD: begin
                n_state = (r_i + CW'(1) < r_cnt) ? ffha_pkg::S_CO_CHK : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_CO_CHK: begin
                n_state = (r_ffree && rfree) ? ffha_pkg::S_CO_SH_RD : ffha_pkg::S_CO_RD;
            end
            ffha_pkg::S_CO_SH_RD: begin
                n_state = (r_k + CW'(1) < r_cnt) ? ffha_pkg::S_CO_SH_WR
                                                 : ffha_pkg::S_CO_RD;
            end
            ffha_pkg::S_CO_SH_WR: n_state = ffha_pkg::S_CO_SH_RD;
            ffha_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = ffha_pkg::S_IDLE;
                end
            end
            default: n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt; n_brk = r_brk; n_i = r_i; n_k = r_k;
        n_start = r_start; n_fsz = r_fsz; n_ffree = r_ffree;
        n_status = r_status; n_aout = r_aout;
        n_ostat = r_ostat; n_oaddr = r_oaddr;
        n_ovalid = r_ovalid;
        we = 1'b0; waddr = r_i[IW-1:0]; wdata = '0; raddr = r_i[IW-1:0];
        add_a = r_start; add_b = rsz;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                n_i = '0; n_start = '0;
                n_status = ffha_pkg::ST_OK; n_aout = '0;
                if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
                    n_status = ffha_pkg::ST_BADFREE;
                    if (s_axis_tdata[31:16] == 16'd0) begin
                        n_status = ffha_pkg::ST_OK;
                    end
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                raddr = r_i[IW-1:0];
            end
            ffha_pkg::S_SCAN_CHK: begin
                n_fsz = rsz;
                n_ffree = rfree;
                if (!r_mode) begin
                    if (rfree && rsz >= r_need) begin
                        we = 1'b1; wdata = {1'b0, rsz};
                        if (rsz > r_need && r_cnt < CW'(ffha_pkg::MAX_BLOCKS)) begin
                            wdata = {1'b0, r_need};
                        end
                        n_status = ffha_pkg::ST_OK;
                        n_aout = 16'(r_start + SW'(ffha_pkg::HEADER_BYTES));
                        n_k = r_cnt;
                    end else begin
                        n_start = sum; n_i = r_i + CW'(1);
                    end
                end else if (r_start + SW'(ffha_pkg::HEADER_BYTES) == {1'b0, r_addr}) begin
                    if (!rfree) begin
                        we = 1'b1; wdata = {1'b1, rsz};
                        n_status = ffha_pkg::ST_OK;
                        n_ffree = 1'b1;
                        // free left neighbor: start the merge pass there
                        if (r_i != '0 && r_ffree) begin
                            n_i = r_i - CW'(1);
                            n_fsz = r_fsz;
                        end
                    end
                end else begin
                    n_start = sum; n_i = r_i + CW'(1);
                end
            end
            ffha_pkg::S_GROW: begin
                add_a = r_brk; add_b = r_need;
                if (r_cnt >= CW'(ffha_pkg::MAX_BLOCKS) || r_need > eff_lim
                        || r_brk > eff_lim - r_need) begin
                    n_status = ffha_pkg::ST_OOM; n_aout = '0;
                end else begin
                    we = 1'b1; waddr = r_cnt[IW-1:0]; wdata = {1'b0, r_need};
                    n_cnt = r_cnt + CW'(1);
                    n_brk = sum;
                    n_status = ffha_pkg::ST_OK;
                    n_aout = 16'(r_brk + SW'(ffha_pkg::HEADER_BYTES));
                end
            end
            ffha_pkg::S_SPLIT_RD: begin
                raddr = IW'(r_k - CW'(1));
            end
            ffha_pkg::S_SPLIT_WR: begin
                we = 1'b1; waddr = r_k[IW-1:0]; wdata = rdata;
                n_k = r_k - CW'(1);
            end
            ffha_pkg::S_SPLIT_END: begin
                we = 1'b1; waddr = IW'(r_i + CW'(1));
                wdata = {1'b1, r_fsz - r_need};
                n_cnt = r_cnt + CW'(1);
            end
            ffha_pkg::S_CO_RD: begin
                raddr = r_i[IW-1:0];
                if (r_i + CW'(1) < r_cnt) begin
                    raddr = IW'(r_i + CW'(1));
                end
            end
            ffha_pkg::S_CO_CHK: begin
                add_a = r_fsz; add_b = rsz;
                if (r_ffree && rfree) begin
                    we = 1'b1; waddr = r_i[IW-1:0]; wdata = {1'b1, sum};
                    n_fsz = sum;
                    n_k = r_i + CW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                    n_fsz = rsz; n_ffree = rfree;
                end
            end
            ffha_pkg::S_CO_SH_RD: begin
                raddr = IW'(r_k + CW'(1));
                if (!(r_k + CW'(1) < r_cnt)) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ffha_pkg::S_CO_SH_WR: begin
                we = 1'b1; waddr = r_k[IW-1:0]; wdata = rdata;
                n_k = r_k + CW'(1);
            end
            ffha_pkg::S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat = r_status;
                    n_oaddr = r_aout;
                end
            end
            default: ;
        endcase
    end
endmodule

@@ bench/first_fit_heap_allocator_core_test.sv @@
// Testbench: first-fit heap allocator checked item by item against a behavioral table model.
`timescale 1ns / 1ps

module first_fit_heap_allocator_core_test;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;
    localparam int   CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    first_fit_heap_allocator_core DUT (.*);

    always #4 i_clk = ~i_clk;

    // model state
    logic [16:0] blk_size [ffha_pkg::MAX_BLOCKS];
    logic        blk_free [ffha_pkg::MAX_BLOCKS];
    int          blk_cnt;
    int          brk;
    int          limit_reg;

    t_reply      replies_due[$];
    int          live_addrs[$];
    int          errors = 0;
    int          n_results = 0;
    int          n_oom = 0;
    int          n_bad = 0;
    int          n_merge = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    longint      cycles = 0;

    function automatic t_reply heap_alloc(input int req);
        t_reply r;
        int need, start, lim;
        need = ((req + ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES - 1)
                / ffha_pkg::ALIGN_BYTES) * ffha_pkg::ALIGN_BYTES;
        start = 0;
        for (int i = 0; i < blk_cnt; i++) begin
            if (blk_free[i] && int'(blk_size[i]) >= need) begin
                if (int'(blk_size[i]) > need && blk_cnt < ffha_pkg::MAX_BLOCKS) begin
                    for (int k = blk_cnt; k > i + 1; k--) begin
                        blk_size[k] = blk_size[k-1];
                        blk_free[k] = blk_free[k-1];
                    end
                    blk_size[i+1] = 17'(int'(blk_size[i]) - need);
                    blk_free[i+1] = 1'b1;
                    blk_cnt++;
                    blk_size[i] = 17'(need);
                end
                blk_free[i] = 1'b0;
                r.status = ffha_pkg::ST_OK;
                r.addr = 16'(start + ffha_pkg::HEADER_BYTES);
                return r;
            end
            start += int'(blk_size[i]);
        end
        lim = (limit_reg < ffha_pkg::HEAP_BYTES) ? limit_reg : ffha_pkg::HEAP_BYTES;
        if (blk_cnt >= ffha_pkg::MAX_BLOCKS || need > lim || brk > lim - need) begin
            r.status = ffha_pkg::ST_OOM;
            r.addr = '0;
            return r;
        end
        blk_size[blk_cnt] = 17'(need);
        blk_free[blk_cnt] = 1'b0;
        blk_cnt++;
        r.status = ffha_pkg::ST_OK;
        r.addr = 16'(brk + ffha_pkg::HEADER_BYTES);
        brk += need;
        return r;
    endfunction

    function automatic t_reply heap_release(input int addr);
        t_reply r;
        int start, i;
        r.addr = '0;
        r.status = ffha_pkg::ST_OK;
        if (addr == 0) return r;
        start = 0;
        for (int j = 0; j < blk_cnt; j++) begin
            if (start + ffha_pkg::HEADER_BYTES == addr) begin
                if (blk_free[j]) begin
                    r.status = ffha_pkg::ST_BADFREE;
                    return r;
                end
                blk_free[j] = 1'b1;
                i = 0;
                while (i + 1 < blk_cnt) begin
                    if (blk_free[i] && blk_free[i+1]) begin
                        blk_size[i] += blk_size[i+1];
                        for (int k = i + 1; k + 1 < blk_cnt; k++) begin
                            blk_size[k] = blk_size[k+1];
                            blk_free[k] = blk_free[k+1];
                        end
                        blk_cnt--;
                        n_merge++;
                    end else begin
                        i++;
                    end
                end
                return r;
            end
            start += int'(blk_size[j]);
        end
        r.status = ffha_pkg::ST_BADFREE;
        return r;
    endfunction

    task automatic send_request(input logic mode, input int req, input int addr);
        t_reply r;
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {16'(addr), 16'(req)};
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        r = (mode == MODE_ALLOC) ? heap_alloc(req) : heap_release(addr);
        if (mode == MODE_ALLOC && r.status == ffha_pkg::ST_OK && r.addr != 0) begin
            live_addrs.push_back(r.addr);
        end
        replies_due.push_back(r);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_limit(input int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 17'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    task automatic free_live(input int pick);
        int a;
        a = live_addrs[pick];
        live_addrs.delete(pick);
        send_request(MODE_FREE, 0, a);
    endtask

    // receiver and checker
    always @(posedge i_clk) begin
        t_reply got, want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_reply'({m_axis_tdata[17:2], m_axis_tdata[1:0]});
                got.status = m_axis_tdata[1:0];
                got.addr = m_axis_tdata[17:2];
                n_results++;
                if (replies_due.size() == 0) begin
                    $error("unexpected result status=%0d address_out=%0d",
                           got.status, got.addr);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (want.status == ffha_pkg::ST_OOM) n_oom++;
                    if (want.status == ffha_pkg::ST_BADFREE) n_bad++;
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.addr !== want.addr) begin
                        $error("address_out expected %0d actual %0d", want.addr, got.addr);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(MODE_FREE, 0, 0);
        send_request(MODE_FREE, 0, 24);
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 100, 16'hFFFF);
        send_request(MODE_ALLOC, 8, 0);
        send_request(MODE_FREE, 0, 56);
        send_request(MODE_FREE, 0, 56);
        send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_FREE, 0, 24);
        send_request(MODE_FREE, 0, 57);
        send_request(MODE_FREE, 0, 65535);
        send_request(MODE_ALLOC, 65535, 0);
        send_request(MODE_ALLOC, 65512, 0);
        live_addrs.delete();
    endtask

    task automatic test_limits();
        set_limit(0);
        send_request(MODE_ALLOC, 0, 0);
        set_limit(200);
        send_request(MODE_ALLOC, 100, 0);
        send_request(MODE_ALLOC, 40, 0);
        send_request(MODE_ALLOC, 0, 0);
        set_limit(131071);
        send_request(MODE_ALLOC, 60000, 0);
        send_request(MODE_ALLOC, 60000, 0);
        set_limit(65536);
        send_request(MODE_ALLOC, 4000, 0);
        // heap may fill to 65536; next payload offset can wrap
        send_request(MODE_ALLOC, 65535, 0);
    endtask

    task automatic test_random(input int n);
        int r, big;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                big = $urandom_range(99);
                if (big < 3) send_request(MODE_ALLOC, $urandom_range(65535), $urandom);
                else send_request(MODE_ALLOC, $urandom_range(big < 70 ? 64 : 600), $urandom);
            end else if (r < 85 && live_addrs.size() != 0) begin
                free_live($urandom_range(live_addrs.size() - 1));
            end else if (r < 92) begin
                send_request(MODE_FREE, $urandom, $urandom);
            end else begin
                send_request(MODE_FREE, $urandom, 24 + 8 * $urandom_range(400));
            end
        end
    endtask

    // full table: many small blocks, then split and growth at 64 entries
    task automatic test_full_table();
        for (int k = 0; k < 70; k++) send_request(MODE_ALLOC, 0, 0);
        for (int k = 0; k < live_addrs.size(); k += 2) send_request(MODE_FREE, 0, live_addrs[k]);
        send_request(MODE_ALLOC, 0, 0);
        while (live_addrs.size() != 0) free_live($urandom_range(live_addrs.size() - 1));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        blk_cnt = 0;
        brk = 0;
        limit_reg = 65536;
        test_directed();
        test_limits();
        set_limit(65536);
        send_idle = 24;
        recv_idle = 60;
        test_random(300);
        test_full_table();
        set_limit(4096);
        send_idle = 60;
        recv_idle = 24;
        test_random(300);
        set_limit(65536);
        send_idle = 0;
        recv_idle = 0;
        test_random(300);
        wait_drained();
        $display("covered %0d results: %0d out of memory, %0d bad frees, %0d merges",
                 n_results, n_oom, n_bad, n_merge);
        $display("limits 0, 200, 4096, 65536 and 131071 with sender and receiver stalls");
        if (errors == 0 && replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
